### rtl/core/piece_sha1_hasher_assert.svh
// Assertion macros for the piece SHA-1 hasher.
`ifndef PIECE_SHA1_HASHER_ASSERT_SVH
`define PIECE_SHA1_HASHER_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on the clock, with the reset held off.
`define PSH_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("piece_sha1_hasher assertion failed");
// Check a property on the clock, during reset too.
`define PSH_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("piece_sha1_hasher assertion failed");
`else
`define PSH_ASSERT(label, clk, rst_n, prop)
`define PSH_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

### rtl/core/psh_pkg.sv
// Package with types and constants of the piece SHA-1 hasher.
`timescale 1ns / 1ps
`default_nettype none
package psh_pkg;
    localparam logic [31:0] DEF_PIECE_LEN = 32'd65536;
    localparam int unsigned NUM_ROUNDS = 80;
    localparam int unsigned NUM_WORDS = 5;
    localparam logic OP_DATA = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } t_state;

    // What follows a compression.
    typedef enum logic [1:0] {
        CTX_DATA,
        CTX_PAD,
        CTX_FINAL
    } t_ctx;

    function automatic logic [31:0] init_word(input logic [2:0] idx);
        logic [31:0] v;
        begin
            case (idx)
                3'd0: v = 32'h67452301;
                3'd1: v = 32'hEFCDAB89;
                3'd2: v = 32'h98BADCFE;
                3'd3: v = 32'h10325476;
                default: v = 32'hC3D2E1F0;
            endcase
            return v;
        end
    endfunction
endpackage
`default_nettype wire

### rtl/core/psh_if.sv
// Channel interfaces of the piece SHA-1 hasher.
`timescale 1ns / 1ps
`default_nettype none
interface psh_byte_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] data_byte;
    modport source (output valid, output op, output data_byte, input ready);
    modport sink (input valid, input op, input data_byte, output ready);
endinterface

interface psh_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    logic [31:0] piece_number;
    logic        short_piece;
    modport source (output valid, output digest_word, output word_index,
                    output last_word, output piece_number, output short_piece,
                    input ready);
    modport sink (input valid, input digest_word, input word_index,
                  input last_word, input piece_number, input short_piece,
                  output ready);
endinterface

interface psh_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/piece_sha1_hasher.sv
// Piece SHA-1 hasher: cuts a byte stream into pieces and hashes each one.
//
// Channels: i_byte_ch takes one word per item (op 0 = data byte, op 1 =
// finish). o_dig_ch gives five digest words per piece, word 0 first,
// tagged with the piece number and a short-piece flag. i_cfg_ch writes
// the piece length in bytes (0 means 2^32); it is taken at any time and
// is meant to be written while the block is idle.
// Flow: each data byte is written into the block memory. Every 64th byte
// of a piece starts a compression: a load step reads the 16-word block
// memory into the schedule window, 80 rounds follow, and an add step
// adds into the chain. A piece end adds padding at one byte per cycle (up
// to 64), 8 length bytes, one or two compressions and the hand-out of the
// five digest words. The single round unit and memory port set the pace.
// Input ready is high only while no block work is in flight.
// Reset: piece length returns to 65536, counters clear, chain reloads.
// Stall: a digest word waits in the output register and the hand-out of
// the next word holds until it is taken; input resumes once the fifth
// word is in the register, while that word may still wait.
`timescale 1ns / 1ps
`default_nettype none
`include "piece_sha1_hasher_assert.svh"
module piece_sha1_hasher #(
    parameter logic [31:0] P_DEF_PIECE_LEN = psh_pkg::DEF_PIECE_LEN
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    psh_byte_if.sink   i_byte_ch,
    psh_cfg_if.sink    i_cfg_ch,
    psh_digest_if.source o_dig_ch
);
    psh_pkg::t_state r_state, n_state;
    psh_pkg::t_ctx   r_ctx;

    logic [31:0] r_plen;
    logic [31:0] r_off;
    logic [31:0] r_piece;
    logic [32:0] r_len;
    logic [31:0] r_tag;
    logic        r_short;
    logic [5:0]  r_fill;
    logic [23:0] r_acc;
    logic        r_first;
    logic [6:0]  r_cnt;
    logic [2:0]  r_widx;
    logic        r_rvld;
    logic [31:0] r_rdata;

    logic [31:0] r_mem [16];
    logic [31:0] r_w [16];
    logic [31:0] r_h [5];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;

    logic [31:0] r_odata;
    logic [2:0]  r_oidx;
    logic        r_olast;
    logic [31:0] r_opiece;
    logic        r_oshort;
    logic        r_ovalid;

    logic        in_acc;
    logic        wr_en;
    logic [7:0]  wr_byte;
    logic [32:0] next_off;
    logic [32:0] limit;
    logic        piece_end;
    logic [63:0] bits;
    logic [5:0]  len_shift;
    logic [7:0]  len_byte;
    logic        out_free;
    logic [31:0] f_val, k_val, t_val, w_new;

    // Handshake and piece bookkeeping
    assign i_byte_ch.ready = (r_state == psh_pkg::ST_IDLE);
    assign i_cfg_ch.ready  = 1'b1;
    assign in_acc    = i_byte_ch.valid && i_byte_ch.ready;
    assign next_off  = {1'b0, r_off} + 33'd1;
    assign limit     = (r_plen == 32'd0) ? {1'b1, 32'd0} : {1'b0, r_plen};
    assign piece_end = (next_off >= limit);
    assign bits      = {28'd0, r_len, 3'b000};
    assign len_shift = {3'(3'd7 - r_fill[2:0]), 3'b000};
    assign len_byte  = 8'(bits >> len_shift);
    assign out_free  = !r_ovalid || o_dig_ch.ready;

    // Select the byte that goes into the block memory
    always_comb begin
        wr_en   = 1'b0;
        wr_byte = 8'h00;
        unique case (r_state)
            psh_pkg::ST_IDLE: begin
                wr_en   = in_acc && (i_byte_ch.op == psh_pkg::OP_DATA);
                wr_byte = i_byte_ch.data_byte;
            end
            psh_pkg::ST_PAD: begin
                wr_en   = 1'b1;
                wr_byte = r_first ? 8'h80 : 8'h00;
            end
            psh_pkg::ST_LEN: begin
                wr_en   = 1'b1;
                wr_byte = len_byte;
            end
            default: begin
                wr_en   = 1'b0;
                wr_byte = 8'h00;
            end
        endcase
    end

    // Round function
    always_comb begin
        if (r_cnt < 7'd20) begin
            f_val = (r_b & r_c) | (~r_b & r_d);
            k_val = psh_pkg::K0;
        end else if (r_cnt < 7'd40) begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = psh_pkg::K1;
        end else if (r_cnt < 7'd60) begin
            f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k_val = psh_pkg::K2;
        end else begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = psh_pkg::K3;
        end
        t_val = {r_a[26:0], r_a[31:27]} + f_val + r_e + k_val + r_w[0];
        w_new = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        w_new = {w_new[30:0], w_new[31]};
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            psh_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_byte_ch.op == psh_pkg::OP_DATA) begin
                        if (r_fill == 6'd63) begin
                            n_state = psh_pkg::ST_LOAD;
                        end else if (piece_end) begin
                            n_state = psh_pkg::ST_PAD;
                        end
                    end else if (r_off != 32'd0) begin
                        n_state = psh_pkg::ST_PAD;
                    end
                end
            end
            psh_pkg::ST_PAD: begin
                if (r_fill == 6'd63) begin
                    n_state = psh_pkg::ST_LOAD;
                end else if (r_fill == 6'd55) begin
                    n_state = psh_pkg::ST_LEN;
                end
            end
            psh_pkg::ST_LEN: begin
                if (r_fill == 6'd63) begin
                    n_state = psh_pkg::ST_LOAD;
                end
            end
            psh_pkg::ST_LOAD: begin
                if (r_cnt == 7'd16) begin
                    n_state = psh_pkg::ST_ROUND;
                end
            end
            psh_pkg::ST_ROUND: begin
                if (r_cnt == 7'(psh_pkg::NUM_ROUNDS - 1)) begin
                    n_state = psh_pkg::ST_ADD;
                end
            end
            psh_pkg::ST_ADD: begin
                unique case (r_ctx)
                    psh_pkg::CTX_DATA:  n_state = psh_pkg::ST_IDLE;
                    psh_pkg::CTX_PAD:   n_state = psh_pkg::ST_PAD;
                    psh_pkg::CTX_FINAL: n_state = psh_pkg::ST_EMIT;
                    default:            n_state = psh_pkg::ST_IDLE;
                endcase
            end
            psh_pkg::ST_EMIT: begin
                if (out_free && r_widx == 3'(psh_pkg::NUM_WORDS - 1)) begin
                    n_state = psh_pkg::ST_IDLE;
                end
            end
            default: n_state = psh_pkg::ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psh_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Block memory: byte-assembled word writes, registered reads
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            if (r_fill[1:0] == 2'd3) begin
                r_mem[r_fill[5:2]] <= {r_acc, wr_byte};
            end else begin
                r_acc <= {r_acc[15:0], wr_byte};
            end
        end
        r_rdata <= r_mem[r_cnt[3:0]];
    end

    // Control counters, piece bookkeeping and chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen  <= P_DEF_PIECE_LEN;
            r_off   <= 32'd0;
            r_piece <= 32'd0;
            r_fill  <= 6'd0;
            r_cnt   <= 7'd0;
            r_widx  <= 3'd0;
            r_rvld  <= 1'b0;
            r_first <= 1'b0;
            r_ctx   <= psh_pkg::CTX_DATA;
            for (int i = 0; i < 5; i++) begin
                r_h[i] <= psh_pkg::init_word(3'(i));
            end
        end else begin
            if (i_cfg_ch.valid) begin
                r_plen <= i_cfg_ch.data;
            end
            if (wr_en) begin
                r_fill <= r_fill + 6'd1;
            end
            r_rvld <= (r_state == psh_pkg::ST_LOAD) && (r_cnt < 7'd16);
            unique case (r_state)
                psh_pkg::ST_IDLE: begin
                    r_cnt <= 7'd0;
                    if (in_acc && i_byte_ch.op == psh_pkg::OP_DATA) begin
                        r_first <= 1'b1;
                        r_tag   <= r_piece;
                        r_short <= 1'b0;
                        r_len   <= next_off;
                        r_ctx   <= piece_end ? psh_pkg::CTX_PAD : psh_pkg::CTX_DATA;
                        if (piece_end) begin
                            r_off   <= 32'd0;
                            r_piece <= r_piece + 32'd1;
                        end else begin
                            r_off <= next_off[31:0];
                        end
                    end else if (in_acc) begin
                        r_first <= 1'b1;
                        r_tag   <= r_piece;
                        r_short <= 1'b1;
                        r_len   <= {1'b0, r_off};
                        r_off   <= 32'd0;
                        r_piece <= 32'd0;
                    end
                end
                psh_pkg::ST_PAD: begin
                    r_first <= 1'b0;
                    r_ctx   <= psh_pkg::CTX_PAD;
                end
                psh_pkg::ST_LEN: begin
                    r_ctx <= psh_pkg::CTX_FINAL;
                end
                psh_pkg::ST_LOAD: begin
                    r_cnt <= (r_cnt == 7'd16) ? 7'd0 : r_cnt + 7'd1;
                end
                psh_pkg::ST_ROUND: begin
                    r_cnt <= r_cnt + 7'd1;
                end
                psh_pkg::ST_ADD: begin
                    r_cnt  <= 7'd0;
                    r_widx <= 3'd0;
                    r_h[0] <= r_h[0] + r_a;
                    r_h[1] <= r_h[1] + r_b;
                    r_h[2] <= r_h[2] + r_c;
                    r_h[3] <= r_h[3] + r_d;
                    r_h[4] <= r_h[4] + r_e;
                end
                psh_pkg::ST_EMIT: begin
                    if (out_free) begin
                        r_widx <= r_widx + 3'd1;
                        if (r_widx == 3'(psh_pkg::NUM_WORDS - 1)) begin
                            r_fill <= 6'd0;
                            for (int i = 0; i < 5; i++) begin
                                r_h[i] <= psh_pkg::init_word(3'(i));
                            end
                        end
                    end
                end
                default: r_cnt <= 7'd0;
            endcase
        end
    end

    // Schedule window and working variables
    always_ff @(posedge i_clk) begin
        if (r_state == psh_pkg::ST_LOAD && r_rvld) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= r_rdata;
        end else if (r_state == psh_pkg::ST_ROUND) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= w_new;
        end
        if (r_state == psh_pkg::ST_LOAD) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (r_state == psh_pkg::ST_ROUND) begin
            r_a <= t_val;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    // Output register: hold a digest word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == psh_pkg::ST_EMIT && out_free) begin
            r_ovalid <= 1'b1;
        end else if (o_dig_ch.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == psh_pkg::ST_EMIT && out_free) begin
            r_odata  <= r_h[r_widx];
            r_oidx   <= r_widx;
            r_olast  <= (r_widx == 3'(psh_pkg::NUM_WORDS - 1));
            r_opiece <= r_tag;
            r_oshort <= r_short;
        end
    end

    assign o_dig_ch.valid        = r_ovalid;
    assign o_dig_ch.digest_word  = r_odata;
    assign o_dig_ch.word_index   = r_oidx;
    assign o_dig_ch.last_word    = r_olast;
    assign o_dig_ch.piece_number = r_opiece;
    assign o_dig_ch.short_piece  = r_oshort;

    `PSH_ASSERT(a_round_cnt, i_clk, i_rst_n,
        (r_state == psh_pkg::ST_ROUND) |-> (r_cnt < 7'(psh_pkg::NUM_ROUNDS)))
    `PSH_ASSERT(a_no_write_in_load, i_clk, i_rst_n,
        (r_state == psh_pkg::ST_LOAD || r_state == psh_pkg::ST_ROUND) |-> !wr_en)
    `PSH_ASSERT(a_word_index, i_clk, i_rst_n,
        r_ovalid |-> (r_oidx <= 3'd4 && r_olast == (r_oidx == 3'd4)))
    `PSH_ASSERT(a_emit_fill, i_clk, i_rst_n,
        (r_state == psh_pkg::ST_EMIT) |-> (r_fill == 6'd0))
endmodule
`default_nettype wire
